// ----- hdl/dqr_pkg.sv -----
// dqr_pkg: shared types and codes for the deduplicating queue.
// No dependencies.
package dqr_pkg;

  typedef enum logic [1:0] {
    REQ_ENQ = 2'd0,
    REQ_DEQ = 2'd1,
    REQ_REM = 2'd2,
    REQ_NOP = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request
    logic exec;   // apply request to the store
  } dqr_cmd_t;

endpackage

// ----- hdl/dqr_dp.sv -----
// dqr_dp: slot store, parallel key match, link updates and result register.
// Depends on dqr_pkg.
module dqr_dp
  import dqr_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32,
  parameter int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dqr_cmd_t            cmd,
  input  logic [1:0]          in_req_type,
  input  logic [31:0]         in_item_key,
  output logic [1:0]          res_status,
  output logic [31:0]         res_item,
  output logic [4:0]          res_occ
);

  logic [1:0]          req_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] slot_key_r [CAPACITY];
  logic [IW-1:0]       slot_next_r [CAPACITY];
  logic [IW-1:0]       slot_prev_r [CAPACITY];
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [IW-1:0]       head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [1:0]          st_r, st_nxt;
  logic [31:0]         item_r, item_nxt;

  logic [CAPACITY-1:0] hit;
  logic                found, freef;
  logic [IW-1:0]       hit_idx, free_idx, uidx, up, un;
  logic                do_unlink, do_enq;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = valid_r[i] && (slot_key_r[i] == key_r);
    end
  end

  // lowest-index match and free slot
  always_comb begin
    found = 1'b0;
    freef = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid_r[i]) begin
        freef = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt = cnt_r;
    st_nxt = ST_OK;
    item_nxt = '0;
    do_unlink = 1'b0;
    do_enq = 1'b0;
    uidx = head_r;
    unique case (req_t'(req_r))
      REQ_ENQ: begin
        if (found) st_nxt = ST_DUP;
        else if (!freef || cnt_r == CW'(CAPACITY)) st_nxt = ST_FULL;
        else do_enq = 1'b1;
      end
      REQ_DEQ: begin
        if (cnt_r == '0) st_nxt = ST_MISS;
        else begin
          do_unlink = 1'b1;
          item_nxt = 32'(slot_key_r[head_r]);
        end
      end
      REQ_REM: begin
        if (!found) st_nxt = ST_MISS;
        else begin
          do_unlink = 1'b1;
          uidx = hit_idx;
        end
      end
      default: ;
    endcase
    up = slot_prev_r[uidx];
    un = slot_next_r[uidx];
    if (do_unlink) begin
      if (uidx == head_r) head_nxt = un;
      if (uidx == tail_r) tail_nxt = up;
      valid_nxt[uidx] = 1'b0;
      cnt_nxt = cnt_r - CW'(1);
    end
    if (do_enq) begin
      valid_nxt[free_idx] = 1'b1;
      if (cnt_r == '0) head_nxt = free_idx;
      tail_nxt = free_idx;
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      key_r <= KEY_BITS'(in_item_key);
    end
    if (cmd.exec) begin
      st_r <= st_nxt;
      item_r <= item_nxt;
      if (do_enq) begin
        slot_key_r[free_idx] <= key_r;
        slot_next_r[free_idx] <= '0;
        slot_prev_r[free_idx] <= (cnt_r == '0) ? '0 : tail_r;
        if (cnt_r != '0) slot_next_r[tail_r] <= free_idx;
      end
      if (do_unlink) begin
        if (uidx != head_r) slot_next_r[up] <= un;
        if (uidx != tail_r) slot_prev_r[un] <= up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      cnt_r <= '0;
    end else if (cmd.exec) begin
      valid_r <= valid_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign res_status = st_r;
  assign res_item = item_r;
  assign res_occ = 5'(cnt_r);

`ifndef SYNTHESIS
  a_cnt_ones: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("count differs from valid slots");
  a_match_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("key held twice");
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> valid_r[head_r] && valid_r[tail_r])
    else $error("head or tail slot not valid");
`endif

endmodule

// ----- hdl/dqr_ctl.sv -----
// dqr_ctl: request sequencer for the queue.
// Depends on dqr_pkg.
module dqr_ctl
  import dqr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dqr_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("load not followed by execute");
  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("execute not followed by result");
`endif

endmodule

// ----- hdl/dedup_queue_with_removal_top.sv -----
// Top level of the deduplicating queue with keyed removal.
// Depends on dqr_pkg, dqr_ctl, dqr_dp.
//
// Usage:
//  - Input channel (in_valid/in_stall): in_req_type 0 enqueue in_item_key,
//    1 dequeue head, 2 remove in_item_key, 3 no operation.
//  - Result channel (out_valid/out_stall): one item per request with
//    out_status (0 ok, 1 duplicate, 2 empty/not found, 3 full),
//    out_item_out (dequeued key, else zero) and out_occupancy.
//  - The request is captured when taken, executed into the result
//    register in the execute state and presented in the output state.
//  - The sequencer handles one request at a time (take, execute,
//    present).
//  - Key match over all slots and the link update happen in the single
//    execute cycle.
//  - A stalled result holds; no new request is taken until it leaves.
//  - Reset (synchronous, rst_n low) empties the queue at once; slot
//    keys and links need no clearing since only valid slots are read.
module dedup_queue_with_removal_top
  import dqr_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_item_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_item_out,
  output logic [4:0]  out_occupancy
);

  dqr_cmd_t cmd;

  dqr_ctl u_ctl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd)
  );

  dqr_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_req_type(in_req_type), .in_item_key(in_item_key),
    .res_status(out_status), .res_item(out_item_out),
    .res_occ(out_occupancy)
  );

endmodule
